FILE: rtl/core/lrt_pkg.sv
// Shared types, codes and constants of the routing table with aging.
package lrt_pkg;

  localparam int TableDepthDefault = 32;

  localparam logic [15:0] MaxAgeReset = 16'd60;

  // Operation codes carried in the action field.
  localparam logic [1:0] ActUpdate = 2'd0;
  localparam logic [1:0] ActLookup = 2'd1;
  localparam logic [1:0] ActExpire = 2'd2;
  localparam logic [1:0] ActTick   = 2'd3;

  // Result status codes.
  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatMiss = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;

  // The removed count saturates at its all-ones value.
  localparam logic [5:0] RemovedMax = 6'h3f;

  // One table slot as kept in the table memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] dest;
    logic [31:0] mask;
    logic [47:0] mac;
    logic [7:0]  port;
    logic [31:0] stamp;
  } entry_t;

  // Swaps the four bytes of a mask word.
  function automatic logic [31:0] byte_reverse(input logic [31:0] v);
    byte_reverse = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

FILE: rtl/core/lrt_if.sv
// Request and response channel interfaces of the routing table.
interface lrt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] dest_addr;
  logic [31:0] prefix_mask;
  logic [47:0] next_hop_mac;
  logic [7:0]  out_port;

  modport source (output valid, action, dest_addr, prefix_mask, next_hop_mac, out_port,
                  input ready);
  modport sink (input valid, action, dest_addr, prefix_mask, next_hop_mac, out_port,
                output ready);
endinterface

interface lrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] hop_mac;
  logic [7:0]  hop_port;
  logic [5:0]  removed_count;

  modport source (output valid, status, hop_mac, hop_port, removed_count, input ready);
  modport sink (input valid, status, hop_mac, hop_port, removed_count, output ready);
endinterface

FILE: rtl/core/lrt_table_ram.sv
// Table memory: one write port and one registered read port.
module lrt_table_ram #(
  parameter int DEPTH = lrt_pkg::TableDepthDefault,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  lrt_pkg::entry_t      wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output lrt_pkg::entry_t      rd_data
);

  lrt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/lpm_route_table_with_aging_top.sv
// Top level of the longest-prefix-match routing table with entry aging.
//
//   channel   direction  beat contents
//   -------   ---------  ----------------------------------------------------
//   req       in         action, dest_addr, prefix_mask, next_hop_mac, out_port
//   rsp       out        status, hop_mac, hop_port, removed_count
//   cfg       in         cfg_wr_en, cfg_wr_data (max_age, no read-back)
//
// Update, lookup and expire scan every slot once through the single read port
// of the table memory: the result is loaded into the output register when the
// scan is done, and an update writes its slot at that same edge. The next
// request can be accepted in the cycle after that edge.
// A tick skips the scan and loads its result straight from the finishing state.
// One request is in work at a time; the next one is accepted while a
// finished result still waits in the output register.
// After reset a clearing pass writes every slot invalid, during which no request
// is accepted; cfg writes are taken throughout.
// A stalled rsp holds the finished result in the scan logic until it drains.
module lpm_route_table_with_aging_top #(
  parameter int TABLE_DEPTH = lrt_pkg::TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  lrt_req_if.sink     req,
  lrt_rsp_if.source   rsp
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] CntLast = CW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] CntEnd  = CW'(TABLE_DEPTH);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]  state;

  // Request held for the length of its scan.
  logic [1:0]  act;
  logic [31:0] q_dest;
  logic [31:0] q_mask;
  logic [47:0] q_mac;
  logic [7:0]  q_port;

  logic [31:0] seconds_now;
  logic [15:0] max_age;

  // Scan sequencing: issue_cnt walks the read addresses, data_vld marks the
  // cycle in which the entry read at data_idx is on the memory output.
  logic [CW-1:0] issue_cnt;
  logic          data_vld;
  logic [AW-1:0] data_idx;

  // Update search.
  logic          found;
  logic [AW-1:0] match_slot;
  logic          free_found;
  logic [AW-1:0] free_slot;

  // Lookup search.
  logic          hit;
  logic [31:0]   best_len;
  logic [31:0]   best_dest;
  logic [47:0]   best_mac;
  logic [7:0]    best_port;

  logic [5:0]    removed;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  lrt_pkg::entry_t rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  lrt_pkg::entry_t wr_data;

  logic        accept;
  logic        leave;
  logic        expired;
  logic        key_hit;
  logic        route_hit;
  logic        better;
  logic [31:0] rev_mask;
  logic [31:0] age;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  // A finished result moves to the output register once that register is free.
  assign leave     = (state == S_FIN) && (!rsp.valid || rsp.ready);

  assign age       = seconds_now - rd_data.stamp;
  assign expired   = rd_data.valid && (age > {16'd0, max_age});
  assign key_hit   = rd_data.valid && (rd_data.dest == q_dest) && (rd_data.mask == q_mask);
  assign route_hit = rd_data.valid && ((q_dest & rd_data.mask) == (rd_data.dest & rd_data.mask));
  assign rev_mask  = lrt_pkg::byte_reverse(rd_data.mask);
  // Longer prefix wins; on equal prefixes the smaller destination word wins.
  assign better    = !hit || (rev_mask > best_len) ||
                     ((rev_mask == best_len) && (rd_data.dest < best_dest));

  always_comb begin
    rd_en   = (state == S_SCAN) && (issue_cnt != CntEnd);
    rd_addr = issue_cnt[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = issue_cnt[AW-1:0];
    wr_data = rd_data;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      S_SCAN: begin
        // Expire clears an aged slot as soon as it is read; later reads hit
        // other slots, so no forwarding is needed.
        if (data_vld && (act == lrt_pkg::ActExpire) && expired) begin
          wr_en         = 1'b1;
          wr_addr       = data_idx;
          wr_data.valid = 1'b0;
        end
      end
      S_FIN: begin
        if (leave && (act == lrt_pkg::ActUpdate) && (found || free_found)) begin
          wr_en         = 1'b1;
          wr_addr       = found ? match_slot : free_slot;
          wr_data.valid = 1'b1;
          wr_data.dest  = q_dest;
          wr_data.mask  = q_mask;
          wr_data.mac   = q_mac;
          wr_data.port  = q_port;
          wr_data.stamp = seconds_now;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  lrt_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= lrt_pkg::MaxAgeReset;
    end else if (cfg_wr_en) begin
      max_age <= cfg_wr_data;
    end
  end

  // Sequencer and search state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      issue_cnt   <= '0;
      data_vld    <= 1'b0;
      seconds_now <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          issue_cnt <= issue_cnt + CW'(1);
          if (issue_cnt == CntLast) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            issue_cnt <= '0;
            data_vld  <= 1'b0;
            if (req.action == lrt_pkg::ActTick) begin
              seconds_now <= seconds_now + 32'd1;
              state       <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          data_vld <= rd_en;
          data_idx <= issue_cnt[AW-1:0];
          if (rd_en) begin
            issue_cnt <= issue_cnt + CW'(1);
          end else if (!data_vld) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (leave) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture and per-entry search updates.
  always_ff @(posedge clk) begin
    if (accept) begin
      act        <= req.action;
      q_dest     <= req.dest_addr;
      q_mask     <= req.prefix_mask;
      q_mac      <= req.next_hop_mac;
      q_port     <= req.out_port;
      found      <= 1'b0;
      free_found <= 1'b0;
      hit        <= 1'b0;
      removed    <= '0;
    end else if ((state == S_SCAN) && data_vld) begin
      unique case (act)
        lrt_pkg::ActUpdate: begin
          if (key_hit && !found) begin
            found      <= 1'b1;
            match_slot <= data_idx;
          end
          if (!rd_data.valid && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= data_idx;
          end
        end
        lrt_pkg::ActLookup: begin
          if (route_hit && better) begin
            hit       <= 1'b1;
            best_len  <= rev_mask;
            best_dest <= rd_data.dest;
            best_mac  <= rd_data.mac;
            best_port <= rd_data.port;
          end
        end
        lrt_pkg::ActExpire: begin
          if (expired && (removed != lrt_pkg::RemovedMax)) begin
            removed <= removed + 6'd1;
          end
        end
        default: begin
          removed <= removed;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (leave) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (leave) begin
      rsp.status        <= lrt_pkg::StatOk;
      rsp.hop_mac       <= '0;
      rsp.hop_port      <= '0;
      rsp.removed_count <= '0;
      unique case (act)
        lrt_pkg::ActUpdate: begin
          if (!found && !free_found) begin
            rsp.status <= lrt_pkg::StatFull;
          end
        end
        lrt_pkg::ActLookup: begin
          if (hit) begin
            rsp.hop_mac  <= best_mac;
            rsp.hop_port <= best_port;
          end else begin
            rsp.status <= lrt_pkg::StatMiss;
          end
        end
        lrt_pkg::ActExpire: begin
          rsp.removed_count <= removed;
        end
        default: begin
          rsp.status <= lrt_pkg::StatOk;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the longest-prefix-match routing table with aging.
module tb;

  localparam int Depth   = lrt_pkg::TableDepthDefault;
  localparam int KeyPool = 40;

  // One expected or observed response beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] mac;
    logic [7:0]  port;
    logic [5:0]  removed;
  } route_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  lrt_req_if req_ch ();
  lrt_rsp_if rsp_ch ();

  lpm_route_table_with_aging_top #(
    .TABLE_DEPTH(Depth)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  // Shadow copy of the route table, the seconds counter and the age limit.
  logic        route_valid [Depth];
  logic [31:0] route_dest  [Depth];
  logic [31:0] route_mask  [Depth];
  logic [47:0] route_mac   [Depth];
  logic [7:0]  route_port  [Depth];
  logic [31:0] route_stamp [Depth];
  logic [31:0] seconds_now;
  logic [15:0] max_age;

  // Responses predicted for accepted requests, oldest first.
  route_result_t pending_results[$];

  int mismatch_count;
  int op_count[4];
  int hit_count, miss_count, drop_count, removed_total, setting_count;

  // Set for the closing stretch of the run, where neither side idles.
  bit tail_mode;

  // Key pool for the random part, so that updates overwrite and lookups hit.
  logic [31:0] key_dest[KeyPool];
  logic [31:0] key_mask[KeyPool];

  // The clock runs free with a period of 12 time units.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Swaps the byte order of a word, turning a network-order mask into
  // a number whose size grows with the prefix length.
  function automatic logic [31:0] swap_bytes(input logic [31:0] w);
    logic [31:0] s;
    s = {w[7:0], w[15:8], w[23:16], w[31:24]};
    return s;
  endfunction

  // Mask word, in network byte order, for a prefix of the given length.
  function automatic logic [31:0] prefix_word(input int len);
    logic [31:0] m;
    m = (len == 0) ? 32'd0 : (~32'd0 << (32 - len));
    return swap_bytes(m);
  endfunction

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Queues a predicted response behind the ones already outstanding.
  function automatic void queue_result(input route_result_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  // Applies one request to the shadow table and returns the response that
  // the block must give for it.
  function automatic route_result_t predict_route_result(
    input logic [1:0]  act,
    input logic [31:0] dest,
    input logic [31:0] mask,
    input logic [47:0] mac,
    input logic [7:0]  port
  );
    route_result_t res;
    int            slot;
    int            best;
    logic          hit;
    logic [31:0]   best_len;
    logic [31:0]   best_dest;
    logic [31:0]   rev;
    logic [31:0]   age;
    int            swept;
    res       = '0;
    slot      = -1;
    best      = 0;
    hit       = 1'b0;
    best_len  = '0;
    best_dest = '0;
    swept     = 0;
    case (act)
      lrt_pkg::ActUpdate: begin
        // An existing entry with the same key wins over the lowest free slot.
        for (int i = 0; i < Depth; i++) begin
          if (slot < 0 && route_valid[i] && route_dest[i] == dest && route_mask[i] == mask)
            slot = i;
        end
        for (int i = 0; i < Depth; i++) begin
          if (slot < 0 && !route_valid[i]) slot = i;
        end
        if (slot >= 0) begin
          route_valid[slot] = 1'b1;
          route_dest[slot]  = dest;
          route_mask[slot]  = mask;
          route_mac[slot]   = mac;
          route_port[slot]  = port;
          route_stamp[slot] = seconds_now;
        end else begin
          res.status = lrt_pkg::StatFull;
          drop_count++;
        end
      end
      lrt_pkg::ActLookup: begin
        for (int i = 0; i < Depth; i++) begin
          if (route_valid[i] && ((dest & route_mask[i]) == (route_dest[i] & route_mask[i])))
          begin
            rev = swap_bytes(route_mask[i]);
            if (!hit || rev > best_len || (rev == best_len && route_dest[i] < best_dest)) begin
              hit       = 1'b1;
              best_len  = rev;
              best_dest = route_dest[i];
              best      = i;
            end
          end
        end
        if (hit) begin
          res.mac  = route_mac[best];
          res.port = route_port[best];
          hit_count++;
        end else begin
          res.status = lrt_pkg::StatMiss;
          miss_count++;
        end
      end
      lrt_pkg::ActExpire: begin
        for (int i = 0; i < Depth; i++) begin
          age = seconds_now - route_stamp[i];
          if (route_valid[i] && age > {16'd0, max_age}) begin
            route_valid[i] = 1'b0;
            swept++;
          end
        end
        res.removed = (swept > 63) ? lrt_pkg::RemovedMax : 6'(swept);
        removed_total += swept;
      end
      lrt_pkg::ActTick: begin
        seconds_now = seconds_now + 32'd1;
      end
    endcase
    return res;
  endfunction

  // Sends one request beat, with a random gap in front of it while the
  // run is not in its closing stretch. The valid stays high after the
  // handshake so that a following beat can go out back to back;
  // wait_drained lowers it at the next falling edge.
  task automatic send_request(
    input logic [1:0]  act,
    input logic [31:0] dest,
    input logic [31:0] mask,
    input logic [47:0] mac,
    input logic [7:0]  port
  );
    int gap;
    if (!tail_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.dest_addr    <= dest;
    req_ch.prefix_mask  <= mask;
    req_ch.next_hop_mac <= mac;
    req_ch.out_port     <= port;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    queue_result(predict_route_result(act, dest, mask, mac, port));
    op_count[act]++;
  endtask

  // Lookup, expire and tick ignore most fields, which carry random values.
  task automatic lookup(input logic [31:0] dest);
    send_request(lrt_pkg::ActLookup, dest, $urandom, rand_mac(), 8'($urandom));
  endtask

  task automatic expire();
    send_request(lrt_pkg::ActExpire, $urandom, $urandom, rand_mac(), 8'($urandom));
  endtask

  task automatic tick();
    send_request(lrt_pkg::ActTick, $urandom, $urandom, rand_mac(), 8'($urandom));
  endtask

  // Holds the sender off until every predicted response has come back.
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // The age limit is only changed while the block is idle.
  task automatic write_max_age(input logic [15:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    max_age = value;
    setting_count++;
  endtask

  task automatic report_field(input string field, input logic [47:0] want, input logic [47:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch in %s at %0t: expected %h, got %h", field, $time, want, got);
  endtask

  // Response checker: every beat taken from the block is compared with the
  // oldest prediction, one field at a time.
  always @(posedge clk) begin
    route_result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected response beat at %0t", $time);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status) report_field("status", 48'(want.status),
                                                        48'(rsp_ch.status));
        if (rsp_ch.hop_mac !== want.mac) report_field("hop_mac", want.mac, rsp_ch.hop_mac);
        if (rsp_ch.hop_port !== want.port) report_field("hop_port", 48'(want.port),
                                                        48'(rsp_ch.hop_port));
        if (rsp_ch.removed_count !== want.removed)
          report_field("removed_count", 48'(want.removed), 48'(rsp_ch.removed_count));
      end
    end
  end

  // The receiver stalls in random bursts, and stays
  // ready throughout the closing stretch.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!tail_mode && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // An empty table misses every query and has nothing to sweep.
  task automatic test_empty_table();
    lookup(32'h0000_0000);
    lookup(32'hFFFF_FFFF);
    expire();
    tick();
  endtask

  // Longest prefix wins, the zero mask serves as a default route, an update
  // to an existing key overwrites it, equal masks go to the smaller dest,
  // and masks that are no prefix still match bit by bit.
  task automatic test_match_rules();
    send_request(lrt_pkg::ActUpdate, 32'h0000_000A, prefix_word(8), rand_mac(), 8'd1);
    send_request(lrt_pkg::ActUpdate, 32'h0001_000A, prefix_word(24), rand_mac(), 8'd2);
    send_request(lrt_pkg::ActUpdate, 32'hFFFF_FFFF, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 8'hFF);
    send_request(lrt_pkg::ActUpdate, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h0, 8'h00);
    lookup(32'h0501_000A);
    lookup(32'h0502_000A);
    lookup(32'h1234_5678);
    lookup(32'hFFFF_FFFF);
    lookup(32'h0000_0000);
    send_request(lrt_pkg::ActUpdate, 32'hFFFF_FFFF, 32'h0000_0000, 48'h0123_4567_89AB, 8'h5A);
    lookup(32'h0000_0000);
    // Two entries with the same /16 mask; the larger dest goes in first.
    send_request(lrt_pkg::ActUpdate, 32'h7700_0B0A, prefix_word(16), rand_mac(), 8'd3);
    send_request(lrt_pkg::ActUpdate, 32'h1100_0B0A, prefix_word(16), rand_mac(), 8'd4);
    lookup(32'h5555_0B0A);
    send_request(lrt_pkg::ActUpdate, 32'hA0B0_C0D0, 32'hF0F0_F0F0, rand_mac(), 8'd5);
    lookup(32'hA5B5_C5D5);
  endtask

  // Filling every slot makes further new keys drop, while an existing key
  // can still be rewritten. A zero age limit then sweeps the whole table.
  task automatic test_table_full();
    for (int i = 0; i < Depth; i++)
      send_request(lrt_pkg::ActUpdate, 32'hC0A8_0000 | i, 32'hFFFF_FFFF, rand_mac(),
                   8'($urandom));
    expire();
    send_request(lrt_pkg::ActUpdate, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rand_mac(), 8'hC3);
    write_max_age(16'd0);
    tick();
    expire();
    lookup(32'h0000_0000);
  endtask

  // An entry survives at an age equal to the limit and goes one second later.
  task automatic test_age_boundary();
    write_max_age(16'd2);
    send_request(lrt_pkg::ActUpdate, 32'h0102_0304, prefix_word(32), rand_mac(), 8'd7);
    expire();
    tick();
    tick();
    expire();
    tick();
    expire();
    write_max_age(16'hFFFF);
    send_request(lrt_pkg::ActUpdate, 32'h0102_0304, prefix_word(32), rand_mac(), 8'd8);
    tick();
    expire();
  endtask

  // Random traffic over a pool of keys, in phases with different age limits.
  // Each phase change drains the block first.
  task automatic test_random_traffic();
    logic [15:0] ages[8];
    int          sel;
    int          k;
    logic [31:0] query;
    ages = '{16'hFFFF, 16'd0, 16'd5, 16'd20, 16'($urandom), 16'd3, 16'd60,
             16'($urandom_range(1, 30))};
    for (int i = 0; i < KeyPool; i++) begin
      key_mask[i] = ($urandom_range(0, 6) == 0) ? $urandom : prefix_word($urandom_range(0, 32));
      key_dest[i] = (i > 0 && $urandom_range(0, 3) == 0) ? key_dest[i - 1] : $urandom;
    end
    for (int p = 0; p < 8; p++) begin
      write_max_age(ages[p]);
      if (p == 7) tail_mode = 1'b1;
      for (int n = 0; n < 100; n++) begin
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, KeyPool - 1);
        if (sel < 35) begin
          if ($urandom_range(0, 19) == 0)
            send_request(lrt_pkg::ActUpdate, $urandom, $urandom, rand_mac(), 8'($urandom));
          else
            send_request(lrt_pkg::ActUpdate, key_dest[k], key_mask[k], rand_mac(),
                         8'($urandom));
        end else if (sel < 75) begin
          query = (key_dest[k] & key_mask[k]) | ($urandom & ~key_mask[k]);
          lookup(($urandom_range(0, 4) == 0) ? 32'($urandom) : query);
        end else if (sel < 85) begin
          expire();
        end else begin
          tick();
        end
        // Now and then the sender waits for the block to run dry.
        if (!tail_mode && $urandom_range(0, 49) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    req_ch.valid        = 1'b0;
    req_ch.action       = lrt_pkg::ActUpdate;
    req_ch.dest_addr    = '0;
    req_ch.prefix_mask  = '0;
    req_ch.next_hop_mac = '0;
    req_ch.out_port     = '0;
    tail_mode           = 1'b0;
    mismatch_count      = 0;
    hit_count           = 0;
    miss_count          = 0;
    drop_count          = 0;
    removed_total       = 0;
    setting_count       = 0;
    op_count            = '{0, 0, 0, 0};
    seconds_now         = '0;
    max_age             = lrt_pkg::MaxAgeReset;
    for (int i = 0; i < Depth; i++) begin
      route_valid[i] = 1'b0;
      route_dest[i]  = '0;
      route_mask[i]  = '0;
      route_mac[i]   = '0;
      route_port[i]  = '0;
      route_stamp[i] = '0;
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // The block runs its clearing pass first; the sender simply waits for
    // ready to come up.
    test_empty_table();
    test_match_rules();
    test_table_full();
    test_age_boundary();
    test_random_traffic();

    // Let the last responses drain, then give the block time to show any
    // stray beat before the verdict.
    wait_drained();
    repeat (Depth + 8) @(posedge clk);

    $display("Covered %0d updates, %0d lookups, %0d expire sweeps and %0d ticks",
             op_count[lrt_pkg::ActUpdate], op_count[lrt_pkg::ActLookup],
             op_count[lrt_pkg::ActExpire], op_count[lrt_pkg::ActTick]);
    $display("over %0d age limits; lookups: %0d hits, %0d misses; %0d updates dropped",
             setting_count, hit_count, miss_count, drop_count);
    $display("on a full table; %0d entries aged out.", removed_total);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop in case the block hangs or loses a response.
  initial begin
    #8000000;
    $display("timeout with %0d responses outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
